// ===== hdl/c816iu_pkg.sv =====
`timescale 1ns / 1ps

package c816iu_pkg;

    // Status flag bit positions: N V M X D I Z C
    localparam int unsigned FlgC = 0;
    localparam int unsigned FlgZ = 1;
    localparam int unsigned FlgI = 2;
    localparam int unsigned FlgD = 3;
    localparam int unsigned FlgX = 4;
    localparam int unsigned FlgM = 5;
    localparam int unsigned FlgV = 6;
    localparam int unsigned FlgN = 7;

    // Command codes
    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Load targets
    localparam logic [2:0] SEL_A     = 3'd0;
    localparam logic [2:0] SEL_X     = 3'd1;
    localparam logic [2:0] SEL_Y     = 3'd2;
    localparam logic [2:0] SEL_SP    = 3'd3;
    localparam logic [2:0] SEL_D     = 3'd4;
    localparam logic [2:0] SEL_FLAGS = 3'd5;
    localparam logic [2:0] SEL_EMU   = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_EXEC   = 2'd0;
    localparam logic [1:0] ST_UNIMPL = 2'd1;
    localparam logic [1:0] ST_LOAD   = 2'd2;

    // Cycle counts
    localparam logic [1:0] CYC_NONE = 2'd0;
    localparam logic [1:0] CYC_TWO  = 2'd2;
    localparam logic [1:0] CYC_XBA  = 2'd3;

    // Opcodes
    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_CLI = 8'h58;
    localparam logic [7:0] OP_SEI = 8'h78;
    localparam logic [7:0] OP_CLV = 8'hB8;
    localparam logic [7:0] OP_CLD = 8'hD8;
    localparam logic [7:0] OP_SED = 8'hF8;
    localparam logic [7:0] OP_TCS = 8'h1B;
    localparam logic [7:0] OP_TSC = 8'h3B;
    localparam logic [7:0] OP_TCD = 8'h5B;
    localparam logic [7:0] OP_TDC = 8'h7B;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_TXY = 8'h9B;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_XBA = 8'hEB;
    localparam logic [7:0] OP_XCE = 8'hFB;
    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_WDM = 8'h42;

    // Reset values
    localparam logic [15:0] SP_RESET    = 16'h01FF;
    localparam logic [7:0]  FLAGS_RESET = 8'h34;
    localparam logic [7:0]  SP_EMU_HI   = 8'h01;

    typedef struct packed {
        logic        command;
        logic [7:0]  opcode;
        logic [2:0]  reg_select;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] acc_out;
        logic [15:0] x_out;
        logic [15:0] y_out;
        logic [15:0] sp_out;
        logic [15:0] dp_out;
        logic [7:0]  flags_out;
        logic        emu_out;
        logic [1:0]  cycles;
    } t_out_item;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  flags;
        logic        emu;
    } t_regs;

    function automatic logic [7:0] nz8(logic [7:0] f, logic [15:0] v);
        logic [7:0] r;
        r = f;
        r[FlgZ] = (v[7:0] == 8'h00);
        r[FlgN] = v[7];
        return r;
    endfunction

    function automatic logic [7:0] nz16(logic [7:0] f, logic [15:0] v);
        logic [7:0] r;
        r = f;
        r[FlgZ] = (v == 16'h0000);
        r[FlgN] = v[15];
        return r;
    endfunction

    // Force the emulation-mode and short-index invariants.
    function automatic t_regs enforce(t_regs s);
        t_regs r;
        r = s;
        if (r.emu) begin
            r.flags[FlgM] = 1'b1;
            r.flags[FlgX] = 1'b1;
            r.sp[15:8]    = SP_EMU_HI;
        end
        if (r.flags[FlgX]) begin
            r.x[15:8] = 8'h00;
            r.y[15:8] = 8'h00;
        end
        return r;
    endfunction

endpackage

// ===== hdl/c816iu_exec.sv =====
`timescale 1ns / 1ps

module c816iu_exec (
    input  c816iu_pkg::t_regs     i_regs,
    input  c816iu_pkg::t_in_item  i_item,
    output c816iu_pkg::t_regs     o_regs,
    output logic [1:0]            o_status,
    output logic [1:0]            o_cycles
);
    import c816iu_pkg::*;

    t_regs      s;
    logic [15:0] idx_src;
    logic [15:0] idx_val;
    logic [7:0]  idx_flags;
    logic        c_old;

    // Transfer into an index register: width follows the X flag.
    always_comb begin
        case (i_item.opcode)
            OP_TXY:  idx_src = i_regs.x;
            OP_TSX:  idx_src = i_regs.sp;
            default: idx_src = i_regs.acc;
        endcase
        if (i_regs.flags[FlgX]) begin
            idx_val   = {8'h00, idx_src[7:0]};
            idx_flags = nz8(i_regs.flags, idx_val);
        end else begin
            idx_val   = idx_src;
            idx_flags = nz16(i_regs.flags, idx_src);
        end
    end

    always_comb begin
        s        = i_regs;
        o_status = ST_EXEC;
        o_cycles = CYC_TWO;
        c_old    = i_regs.flags[FlgC];
        if (i_item.command == CMD_LOAD) begin
            case (i_item.reg_select)
                SEL_A:     s.acc   = i_item.value;
                SEL_X:     s.x     = i_item.value;
                SEL_Y:     s.y     = i_item.value;
                SEL_SP:    s.sp    = i_item.value;
                SEL_D:     s.dp    = i_item.value;
                SEL_FLAGS: s.flags = i_item.value[7:0];
                SEL_EMU:   s.emu   = i_item.value[0];
                default:   s       = i_regs;
            endcase
            s        = enforce(s);
            o_status = ST_LOAD;
            o_cycles = CYC_NONE;
        end else begin
            case (i_item.opcode)
                OP_CLC: s.flags[FlgC] = 1'b0;
                OP_SEC: s.flags[FlgC] = 1'b1;
                OP_CLI: s.flags[FlgI] = 1'b0;
                OP_SEI: s.flags[FlgI] = 1'b1;
                OP_CLV: s.flags[FlgV] = 1'b0;
                OP_CLD: s.flags[FlgD] = 1'b0;
                OP_SED: s.flags[FlgD] = 1'b1;
                OP_TCS: s.sp = i_regs.emu ? {SP_EMU_HI, i_regs.acc[7:0]} : i_regs.acc;
                OP_TXS: s.sp = i_regs.emu ? {SP_EMU_HI, i_regs.x[7:0]} : i_regs.x;
                OP_TSC: begin
                    s.acc   = i_regs.sp;
                    s.flags = nz16(i_regs.flags, i_regs.sp);
                end
                OP_TCD: begin
                    s.dp    = i_regs.acc;
                    s.flags = nz16(i_regs.flags, i_regs.acc);
                end
                OP_TDC: begin
                    s.acc   = i_regs.dp;
                    s.flags = nz16(i_regs.flags, i_regs.dp);
                end
                OP_TYA: begin
                    if (i_regs.flags[FlgM]) begin
                        s.acc   = {i_regs.acc[15:8], i_regs.y[7:0]};
                        s.flags = nz8(i_regs.flags, s.acc);
                    end else begin
                        s.acc   = i_regs.y;
                        s.flags = nz16(i_regs.flags, i_regs.y);
                    end
                end
                OP_TXY, OP_TAY: begin
                    s.y     = idx_val;
                    s.flags = idx_flags;
                end
                OP_TAX, OP_TSX: begin
                    s.x     = idx_val;
                    s.flags = idx_flags;
                end
                OP_XBA: begin
                    s.acc    = {i_regs.acc[7:0], i_regs.acc[15:8]};
                    s.flags  = nz8(i_regs.flags, s.acc);
                    o_cycles = CYC_XBA;
                end
                OP_XCE: begin
                    s.flags[FlgC] = i_regs.emu;
                    s.emu         = c_old;
                    s             = enforce(s);
                end
                OP_NOP, OP_WDM: s = i_regs;
                default: begin
                    o_status = ST_UNIMPL;
                    o_cycles = CYC_NONE;
                end
            endcase
        end
        o_regs = s;
    end

endmodule

// ===== hdl/cpu65816_implied_ops_unit.sv =====
`timescale 1ns / 1ps
// Channel  Valid         Stall         Payload
// input    i_in_valid    o_in_stall    i_in_data  (t_in_item)
// output   o_out_valid   i_out_stall   o_out_data (t_out_item)
//
// Items pass the input register, then execute into the register file
// and the result register. One item per cycle is sustained unless stalled.
// Synchronous active-low reset restores the register file (SP 01FF,
// flags 34, emulation on) and empties both stages.
// A stalled result holds both stages; the input side stalls only when
// its register is full and cannot advance.

module cpu65816_implied_ops_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  c816iu_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output c816iu_pkg::t_out_item o_out_data
);
    import c816iu_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_regs     r_regs;
    t_regs     n_regs;
    logic [1:0] n_status;
    logic [1:0] n_cycles;
    logic      w_out_free;
    logic      w_advance;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_advance  = r_in_vld && w_out_free;
    assign o_in_stall = r_in_vld && !w_out_free;

    c816iu_exec u_exec (
        .i_regs   (r_regs),
        .i_item   (r_in),
        .o_regs   (n_regs),
        .o_status (n_status),
        .o_cycles (n_cycles)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.acc   <= '0;
            r_regs.x     <= '0;
            r_regs.y     <= '0;
            r_regs.sp    <= SP_RESET;
            r_regs.dp    <= '0;
            r_regs.flags <= FLAGS_RESET;
            r_regs.emu   <= 1'b1;
            r_out_vld    <= 1'b0;
        end else begin
            if (w_advance) begin
                r_regs <= n_regs;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out.status    <= n_status;
            r_out.acc_out   <= n_regs.acc;
            r_out.x_out     <= n_regs.x;
            r_out.y_out     <= n_regs.y;
            r_out.sp_out    <= n_regs.sp;
            r_out.dp_out    <= n_regs.dp;
            r_out.flags_out <= n_regs.flags;
            r_out.emu_out   <= n_regs.emu;
            r_out.cycles    <= n_cycles;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_emu_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.emu |-> (r_regs.sp[15:8] == SP_EMU_HI)
    ) else $error("stack high byte not 1 in emulation mode");

    a_emu_mx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.emu |-> (r_regs.flags[FlgM] && r_regs.flags[FlgX])
    ) else $error("M or X clear in emulation mode");

    a_short_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.flags[FlgX] |-> (r_regs.x[15:8] == 8'h00 && r_regs.y[15:8] == 8'h00)
    ) else $error("index high byte set with short index");

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.acc_out == r_regs.acc && r_out.sp_out == r_regs.sp
                       && r_out.flags_out == r_regs.flags && r_out.emu_out == r_regs.emu)
    ) else $error("pending result disagrees with register file");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_vld
    ) else $error("advanced item did not reach result register");

endmodule
